// ===== design/erxf_pkg.sv =====
// ----------------------------------------------------------------------------
// erxf_pkg
// Shared types and constants of the receive address filter.
// ----------------------------------------------------------------------------
package erxf_pkg;

    localparam int MAC_W      = 48;
    localparam int HASH_W     = 6;
    localparam int CRC_W      = 32;
    localparam int KIND_W     = 3;
    localparam int CNT_W      = 7;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 64;
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    localparam logic [CNT_W-1:0] MAX_LIST = 7'd64;

    localparam logic [MAC_W-1:0] BCAST_ADDR = 48'hFFFF_FFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY   = 32'h04C1_1DB7;

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_STATION   = 2'd0;
    localparam logic [1:0] REG_PROMISC   = 2'd1;
    localparam logic [1:0] REG_BCAST_DIS = 2'd2;
    localparam logic [1:0] REG_MCAST_EN  = 2'd3;

    // match kinds
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PROMISC = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BCAST   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MCAST   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INDIV   = 3'd4;

    typedef struct packed {
        logic [MAC_W-1:0] station_address;
        logic             promiscuous;
        logic             broadcast_disable;
        logic             multicast_enable;
    } cfg_t;

    typedef struct packed {
        logic init;
        logic step;
    } crc_ctrl_t;

endpackage

// ===== design/erxf_cfg.sv =====
// ----------------------------------------------------------------------------
// erxf_cfg
// APB register file holding the station address and filter mode bits.
// ----------------------------------------------------------------------------
module erxf_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [erxf_pkg::APB_AW-1:0]  paddr,
    input  logic [erxf_pkg::APB_DW-1:0]  pwdata,
    output logic [erxf_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output erxf_pkg::cfg_t               cfg
);

    erxf_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:3];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                erxf_pkg::REG_STATION:   cfg_reg.station_address <= pwdata[erxf_pkg::MAC_W-1:0];
                erxf_pkg::REG_PROMISC:   cfg_reg.promiscuous       <= pwdata[0];
                erxf_pkg::REG_BCAST_DIS: cfg_reg.broadcast_disable <= pwdata[0];
                erxf_pkg::REG_MCAST_EN:  cfg_reg.multicast_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            erxf_pkg::REG_STATION:   prdata[erxf_pkg::MAC_W-1:0] = cfg_reg.station_address;
            erxf_pkg::REG_PROMISC:   prdata[0] = cfg_reg.promiscuous;
            erxf_pkg::REG_BCAST_DIS: prdata[0] = cfg_reg.broadcast_disable;
            erxf_pkg::REG_MCAST_EN:  prdata[0] = cfg_reg.multicast_enable;
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== design/erxf_crc_unit.sv =====
// ----------------------------------------------------------------------------
// erxf_crc_unit
// Byte-at-a-time CRC-32 engine, reused for every byte of an address.
// ----------------------------------------------------------------------------
module erxf_crc_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  erxf_pkg::crc_ctrl_t         ctrl,
    input  logic [7:0]                  data_byte,
    output logic [erxf_pkg::CRC_W-1:0]  crc
);

    logic [erxf_pkg::CRC_W-1:0] crc_reg;
    logic [erxf_pkg::CRC_W-1:0] crc_next;

    // byte enters lsb first, register shifts msb first
    always_comb
    begin
        logic                       fb;
        logic [erxf_pkg::CRC_W-1:0] c;
        c = crc_reg;
        for (int b = 0; b < 8; b++)
        begin
            fb = c[erxf_pkg::CRC_W-1] ^ data_byte[b];
            c  = {c[erxf_pkg::CRC_W-2:0], 1'b0} ^ (fb ? erxf_pkg::CRC_POLY : '0);
        end
        crc_next = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= erxf_pkg::CRC_INIT;
        end
        else if (ctrl.init)
        begin
            crc_reg <= erxf_pkg::CRC_INIT;
        end
        else if (ctrl.step)
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

// ===== design/ethernet_rx_address_filter.sv =====
// ----------------------------------------------------------------------------
// ethernet_rx_address_filter
// Receive address filter with a 64-bit multicast hash table.
// ----------------------------------------------------------------------------
// Input words arrive on s_tvalid/s_tready: s_tdata holds the 48-bit address,
// s_tuser[0] selects a multicast list load (1) or a frame check (0) and
// s_tuser[1] restarts the list on a load word. Every input word yields one
// result word on m_tvalid/m_tready.
// An address is hashed by one CRC-32 engine that takes a byte per cycle; a word
// passes through the accept step, a CRC step for each of its six bytes and one
// decision step that writes the output register. s_tready is high only while the
// sequencer is idle, so a new word is not taken before the last one is decided.
// The result stays in the output register until taken; the decision cycle
// waits while a previous result is still pending, and no input is taken
// meanwhile.
// Reset clears the hash table, the list entry count and all mode registers.
// Registers sit on an APB port at 8-byte steps: station address, promiscuous,
// broadcast disable, multicast enable.
// ----------------------------------------------------------------------------
module ethernet_rx_address_filter
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [erxf_pkg::IN_DATA_W-1:0]   s_tdata,   // [47:0] mac_address
    input  logic [erxf_pkg::IN_USER_W-1:0]   s_tuser,   // [0] req_type, [1] list_start
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] accepted, [3:1] match_kind, [4] group_flag, [10:5] hash_index, [15:11] zero
    output logic [erxf_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [erxf_pkg::APB_AW-1:0]      paddr,
    input  logic [erxf_pkg::APB_DW-1:0]      pwdata,
    output logic [erxf_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CRC    = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t                              state_reg, state_next;
    logic [2:0]                          cnt_reg, cnt_next;
    logic [erxf_pkg::MAC_W-1:0]          mac_reg;
    logic                                load_reg;
    logic                                start_reg;
    logic [63:0]                         table_reg, table_next;
    logic [erxf_pkg::CNT_W-1:0]          entries_reg, entries_next;
    logic                                m_valid_reg, m_valid_next;
    logic [erxf_pkg::OUT_DATA_W-1:0]     out_reg, out_next;

    erxf_pkg::cfg_t                      cfg;
    erxf_pkg::crc_ctrl_t                 crc_ctrl;
    logic [erxf_pkg::CRC_W-1:0]          crc;
    logic [7:0]                          cur_byte;
    logic [erxf_pkg::HASH_W-1:0]         hash;
    logic                                in_fire;
    logic                                out_free;

    erxf_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    erxf_crc_unit u_crc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (crc_ctrl),
        .data_byte (cur_byte),
        .crc       (crc)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid & s_tready;
    assign out_free = ~m_valid_reg | m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;
    assign hash     = crc[7:2];

    assign crc_ctrl.init = in_fire;
    assign crc_ctrl.step = (state_reg == ST_CRC);

    // first wire byte sits in the top bits
    always_comb
    begin
        case (cnt_reg)
            3'd0:    cur_byte = mac_reg[47:40];
            3'd1:    cur_byte = mac_reg[39:32];
            3'd2:    cur_byte = mac_reg[31:24];
            3'd3:    cur_byte = mac_reg[23:16];
            3'd4:    cur_byte = mac_reg[15:8];
            3'd5:    cur_byte = mac_reg[7:0];
            default: cur_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        logic                         acc;
        logic [erxf_pkg::KIND_W-1:0]  kind;
        logic                         grp;
        logic [63:0]                  tbl_base;
        logic [erxf_pkg::CNT_W-1:0]   cnt_base;

        state_next   = state_reg;
        cnt_next     = cnt_reg;
        table_next   = table_reg;
        entries_next = entries_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        out_next     = out_reg;
        acc          = 1'b0;
        kind         = erxf_pkg::KIND_NONE;
        grp          = 1'b0;
        tbl_base     = start_reg ? 64'd0 : table_reg;
        cnt_base     = start_reg ? '0 : entries_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_CRC;
                    cnt_next   = 3'd0;
                end
            end
            ST_CRC:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    if (load_reg)
                    begin
                        table_next   = tbl_base;
                        entries_next = cnt_base;
                        if (cnt_base < erxf_pkg::MAX_LIST)
                        begin
                            table_next   = tbl_base | (64'd1 << hash);
                            entries_next = cnt_base + 7'd1;
                        end
                    end
                    else if (cfg.promiscuous)
                    begin
                        acc  = 1'b1;
                        kind = erxf_pkg::KIND_PROMISC;
                    end
                    else if (mac_reg == erxf_pkg::BCAST_ADDR)
                    begin
                        if (!cfg.broadcast_disable)
                        begin
                            acc  = 1'b1;
                            kind = erxf_pkg::KIND_BCAST;
                            grp  = 1'b1;
                        end
                    end
                    else if (mac_reg[40])
                    begin
                        if (cfg.multicast_enable && table_reg[hash])
                        begin
                            acc  = 1'b1;
                            kind = erxf_pkg::KIND_MCAST;
                            grp  = 1'b1;
                        end
                    end
                    else if (mac_reg == cfg.station_address)
                    begin
                        acc  = 1'b1;
                        kind = erxf_pkg::KIND_INDIV;
                    end
                    out_next     = {5'd0, hash, grp, kind, acc};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 3'd0;
            table_reg   <= '0;
            entries_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            table_reg   <= table_next;
            entries_reg <= entries_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (in_fire)
        begin
            mac_reg   <= s_tdata;
            load_reg  <= s_tuser[0];
            start_reg <= s_tuser[1];
        end
    end

endmodule
